// ===== hw/rtl/sjrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjrq_pkg: shared definitions for the shortest-job ready queue
// Field widths, default sizes and result status codes.
// ----------------------------------------------------------------------------
package sjrq_pkg;

    localparam int JOB_W      = 8;    // job identifier
    localparam int BURST_W    = 16;   // burst field on the request and response
    localparam int STATUS_W   = 2;

    localparam int DEPTH_DEF      = 16;
    localparam int BURST_BITS_DEF = 16;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXTRACTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

endpackage

// ===== hw/rtl/sjrq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjrq_if: request and response channels of the shortest-job ready queue
// Valid/ready handshake; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sjrq_req_if
    import sjrq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [JOB_W-1:0]   job_id;
    logic [BURST_W-1:0] burst;

    modport source (output valid, cmd, job_id, burst, input ready);
    modport sink   (input valid, cmd, job_id, burst, output ready);
endinterface

interface sjrq_rsp_if
    import sjrq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) ();
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    out_job_id;
    logic [BURST_W-1:0]  out_burst;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_job_id, out_burst, occupancy, input ready);
    modport sink   (input valid, status, out_job_id, out_burst, occupancy, output ready);
endinterface

// ===== hw/rtl/shortest_job_ready_queue_top.sv =====
`timescale 1ns / 1ps
// An insert or a refused request goes from accept to S_FIN, which loads the response register.
// Extract: S_SCAN reads every held slot, S_SHIFT closes up behind the winner, then S_FIN.
// The winner search reads one slot per cycle through the single registered read port, and the gap
// is closed through the same read port and the write port, one slot per cycle.
// One request at a time; the next is taken while the previous response awaits its sink.
// Reset (synchronous, active low) clears control state and job count; slots are not cleared.
// ----------------------------------------------------------------------------
// shortest_job_ready_queue_top: shortest-job-first ready queue
// Bounded table in arrival order; extract removes the smallest burst,
// the oldest job winning a tie, and closes up the gap.
// ----------------------------------------------------------------------------
module shortest_job_ready_queue_top
    import sjrq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sjrq_req_if.sink     i_req,
    sjrq_rsp_if.source   o_rsp
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = JOB_W + BURST_BITS;

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;   // min search, one slot a cycle
    localparam logic [1:0] S_SHIFT = 2'd2;   // close up the gap behind the winner
    localparam logic [1:0] S_FIN   = 2'd3;   // hand result to the response register

    // slot memory: {job, burst}, one write and one registered read a cycle
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]   r_best_idx, n_best_idx;
    logic [JOB_W-1:0]    r_best_job, n_best_job;
    logic [BURST_BITS-1:0] r_best_burst, n_best_burst;

    // staged result
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [JOB_W-1:0]    r_res_job, n_res_job;
    logic [BURST_W-1:0]  r_res_burst, n_res_burst;

    // response register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [JOB_W-1:0]    r_out_job, n_out_job;
    logic [BURST_W-1:0]  r_out_burst, n_out_burst;
    logic [CNT_W-1:0]    r_out_occ, n_out_occ;

    logic                  w_accept;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic                  w_wr_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [WORD_W-1:0]     w_wr_data;
    logic [JOB_W-1:0]      w_rd_job;
    logic [BURST_BITS-1:0] w_rd_burst;
    logic                  w_take;
    logic [ADDR_W-1:0]     w_cand_idx;
    logic [JOB_W-1:0]      w_cand_job;
    logic [BURST_BITS-1:0] w_cand_burst;
    logic                  w_last_scan;
    logic                  w_last_shift;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.out_job_id = r_out_job;
    assign o_rsp.out_burst  = r_out_burst;
    assign o_rsp.occupancy  = r_out_occ;

    // the shared compare: slot arriving from memory against the best so far;
    // strict less-than keeps the oldest job on a tie
    assign w_rd_job     = r_rd_data[WORD_W-1:BURST_BITS];
    assign w_rd_burst   = r_rd_data[BURST_BITS-1:0];
    assign w_take       = (r_idx == '0) || (w_rd_burst < r_best_burst);
    assign w_cand_idx   = w_take ? r_idx      : r_best_idx;
    assign w_cand_job   = w_take ? w_rd_job   : r_best_job;
    assign w_cand_burst = w_take ? w_rd_burst : r_best_burst;

    assign w_last_scan  = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign w_last_shift = (CNT_W'(r_idx) == r_count - CNT_W'(2));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_best_idx   = r_best_idx;
        n_best_job   = r_best_job;
        n_best_burst = r_best_burst;
        n_res_status = r_res_status;
        n_res_job    = r_res_job;
        n_res_burst  = r_res_burst;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_job    = r_out_job;
        n_out_burst  = r_out_burst;
        n_out_occ    = r_out_occ;
        w_rd_addr    = r_idx + ADDR_W'(1);
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_job   = '0;
                    n_res_burst = '0;
                    n_state     = S_FIN;
                    if (i_req.cmd == CMD_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_wr_en      = 1'b1;
                            w_wr_addr    = r_count[ADDR_W-1:0];
                            w_wr_data    = {i_req.job_id, BURST_BITS'(i_req.burst)};
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = ST_INSERTED;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        w_rd_addr = '0;
                        n_idx     = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_best_idx   = w_cand_idx;
                n_best_job   = w_cand_job;
                n_best_burst = w_cand_burst;
                if (w_last_scan) begin
                    n_res_status = ST_EXTRACTED;
                    n_res_job    = w_cand_job;
                    n_res_burst  = BURST_W'(w_cand_burst);
                    if (w_cand_idx == r_idx) begin
                        // winner is the newest slot: nothing to close up
                        n_count = r_count - CNT_W'(1);
                        n_state = S_FIN;
                    end else begin
                        n_idx     = w_cand_idx;
                        w_rd_addr = w_cand_idx + ADDR_W'(1);
                        n_state   = S_SHIFT;
                    end
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_SHIFT: begin
                // slot idx+1 is in the read register; move it down one place
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = r_rd_data;
                w_rd_addr = r_idx + ADDR_W'(2);
                n_idx     = r_idx + ADDR_W'(1);
                if (w_last_shift) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_job    = r_res_job;
                    n_out_burst  = r_res_burst;
                    n_out_occ    = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_best_idx   <= n_best_idx;
        r_best_job   <= n_best_job;
        r_best_burst <= n_best_burst;
        r_res_status <= n_res_status;
        r_res_job    <= n_res_job;
        r_res_burst  <= n_res_burst;
        r_out_status <= n_out_status;
        r_out_job    <= n_out_job;
        r_out_burst  <= n_out_burst;
        r_out_occ    <= n_out_occ;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job count beyond table depth");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.cmd == CMD_INSERT && r_count != CNT_W'(DEPTH))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_best_behind_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx != '0) |-> (r_best_idx < r_idx))
        else $error("best slot ahead of scan position");

    a_shift_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_FIN)
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("extract did not shrink the table");

    a_fin_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !o_rsp.ready) |=> (r_state == S_FIN))
        else $error("result left while response register blocked");

endmodule

// ===== sim/tb_shortest_job_ready_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_job_ready_queue_top: self-checking bench for the SJF ready queue
// Drives insert and extract requests through the request channel with random
// gaps and back-pressure. Each accepted request is run through a table model
// kept in arrival order. Every response is checked field by field against the
// oldest predicted response.
// ----------------------------------------------------------------------------
module tb_shortest_job_ready_queue_top;
    import sjrq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int BURST_BITS = 16;
    localparam int OCC_W      = $clog2(DEPTH + 1);

    // Percentage of cycles in which either side holds back
    localparam int IDLE_PCT = 27;

    // No idling on either side while the accepted count is in this window
    localparam int CALM_FROM = 700;
    localparam int CALM_TO   = 1000;

    localparam int RANDOM_REQS = 1628;
    localparam int STALL_LIMIT = 2000;

    // Sized to cover the longest extract to the response register, with a margin on top
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    // Bits of the burst that the table keeps
    localparam logic [BURST_W-1:0] BURST_KEEP =
        (BURST_BITS >= BURST_W) ? {BURST_W{1'b1}} : BURST_W'((1 << BURST_BITS) - 1);

    typedef struct packed {
        logic               cmd;
        logic [JOB_W-1:0]   job_id;
        logic [BURST_W-1:0] burst;
    } sched_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [JOB_W-1:0]    job_id;
        logic [BURST_W-1:0]  burst;
        logic [OCC_W-1:0]    occ;
    } sched_rsp_t;

    typedef struct packed {
        logic [JOB_W-1:0]   job_id;
        logic [BURST_W-1:0] burst;
    } job_entry_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sjrq_req_if                   req_ch ();
    sjrq_rsp_if #(.DEPTH(DEPTH))  rsp_ch ();

    shortest_job_ready_queue_top #(
        .DEPTH      (DEPTH),
        .BURST_BITS (BURST_BITS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #6 clk = ~clk;

    // Requests waiting for the driver, in order
    sched_req_t job_reqs[$];
    // Responses predicted for accepted requests, oldest first
    sched_rsp_t due_replies[$];
    // Model of the ready table, oldest job at index 0
    job_entry_t ready_tab[$];

    sched_req_t cur_req;
    int         n_accepted = 0;
    int         n_errors   = 0;
    int         n_inserts  = 0;
    int         n_extracts = 0;
    int         n_full     = 0;
    int         n_empty    = 0;
    int         peak_occ   = 0;
    int         stall_cnt  = 0;
    logic       calm;

    // Both sides run flat out for a stretch in the middle of the random part
    assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

    task automatic report_mismatch(input string msg);
        // Keep the log readable if things go badly wrong; every miss still counts
        if (n_errors < 50) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    // Applies one request to the table model and returns the response it must produce.
    // Extract picks the smallest burst scanning from the oldest job; strict less-than
    // keeps the earliest job on a tie. Deleting from the queue closes the gap in order.
    function automatic sched_rsp_t sjf_apply(input sched_req_t r);
        sched_rsp_t rsp;
        job_entry_t ent;
        int         best;
        rsp = '0;
        if (r.cmd == CMD_INSERT) begin
            if (ready_tab.size() >= DEPTH) begin
                rsp.status = ST_FULL;
                n_full++;
            end else begin
                ent.job_id = r.job_id;
                ent.burst  = r.burst & BURST_KEEP;
                ready_tab.push_back(ent);
                rsp.status = ST_INSERTED;
                n_inserts++;
            end
        end else if (ready_tab.size() == 0) begin
            rsp.status = ST_EMPTY;
            n_empty++;
        end else begin
            best = 0;
            for (int i = 1; i < ready_tab.size(); i++) begin
                if (ready_tab[i].burst < ready_tab[best].burst) begin
                    best = i;
                end
            end
            rsp.job_id = ready_tab[best].job_id;
            rsp.burst  = ready_tab[best].burst;
            ready_tab.delete(best);
            rsp.status = ST_EXTRACTED;
            n_extracts++;
        end
        rsp.occ = OCC_W'(ready_tab.size());
        if (ready_tab.size() > peak_occ) begin
            peak_occ = ready_tab.size();
        end
        return rsp;
    endfunction

    task automatic queue_req(input logic cmd, input logic [JOB_W-1:0] id,
                             input logic [BURST_W-1:0] burst);
        sched_req_t r;
        r.cmd    = cmd;
        r.job_id = id;
        r.burst  = burst;
        job_reqs.push_back(r);
    endtask

    // Bursts: small values often so that ties are common, extremes now and then
    function automatic logic [BURST_W-1:0] pick_burst();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            return BURST_W'($urandom_range(7));
        end else if (roll < 45) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return BURST_W'(1);
                2:       return {BURST_W{1'b1}} - 1'b1;
                default: return {BURST_W{1'b1}};
            endcase
        end
        return BURST_W'($urandom_range(65535));
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: holds a request until it is taken, then predicts its
    // response at the edge of acceptance. Fields stay put while idle.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            // valid and ready both high at this edge: the request is taken
            if (req_ch.valid) begin
                due_replies.push_back(sjf_apply(cur_req));
                n_accepted++;
            end
            if (job_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                cur_req        = job_reqs.pop_front();
                req_ch.valid  <= 1'b1;
                req_ch.cmd    <= cur_req.cmd;
                req_ch.job_id <= cur_req.job_id;
                req_ch.burst  <= cur_req.burst;
            end else begin
                req_ch.valid  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: random back-pressure, and each taken response is
    // compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        sched_rsp_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_replies.size() == 0) begin
                    report_mismatch($sformatf("response with nothing outstanding, status %0d",
                                              rsp_ch.status));
                end else begin
                    want = due_replies.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                    end
                    if (rsp_ch.out_job_id !== want.job_id) begin
                        report_mismatch($sformatf("job id 0x%02h, expected 0x%02h",
                                                  rsp_ch.out_job_id, want.job_id));
                    end
                    if (rsp_ch.out_burst !== want.burst) begin
                        report_mismatch($sformatf("burst %0d, expected %0d",
                                                  rsp_ch.out_burst, want.burst));
                    end
                    if (rsp_ch.occupancy !== want.occ) begin
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  rsp_ch.occupancy, want.occ));
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without a handshake on either channel means a hang
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     $realtime, STALL_LIMIT, due_replies.size());
            $display("shortest_job_ready_queue_top test failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n_random;
        int run;
        int ins_pct;

        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_INSERT;
        req_ch.job_id = '0;
        req_ch.burst  = '0;
        rsp_ch.ready  = 1'b0;

        // Directed: extract from an empty table first
        queue_req(CMD_EXTRACT, 8'h00, 16'h0000);
        // Fill to the brim: id and burst extremes, ties at zero and at seven
        queue_req(CMD_INSERT, 8'h10, 16'd500);
        queue_req(CMD_INSERT, 8'h00, 16'hFFFF);
        queue_req(CMD_INSERT, 8'hFF, 16'h0000);
        queue_req(CMD_INSERT, 8'h21, 16'h0000);
        queue_req(CMD_INSERT, 8'h32, 16'd7);
        queue_req(CMD_INSERT, 8'h43, 16'd7);
        queue_req(CMD_INSERT, 8'h54, 16'hFFFF);
        queue_req(CMD_INSERT, 8'hA5, 16'h5A5A);
        queue_req(CMD_INSERT, 8'h5A, 16'hA5A5);
        for (int i = 0; i < 7; i++) begin
            queue_req(CMD_INSERT, JOB_W'(8'h60 + i), BURST_W'(1000 + i));
        end
        // Table full: this job is refused
        queue_req(CMD_INSERT, 8'hEE, 16'd1);
        // Pull out the tied leaders and check oldest-first ordering
        for (int i = 0; i < 5; i++) begin
            queue_req(CMD_EXTRACT, 8'hFF, 16'hFFFF);
        end

        // Random: phases leaning towards filling, draining or neither, so that
        // the table swings between empty and full many times
        n_random = 0;
        while (n_random < RANDOM_REQS) begin
            case ($urandom_range(2))
                0:       ins_pct = 20;
                1:       ins_pct = 50;
                default: ins_pct = 85;
            endcase
            run = $urandom_range(10, 60);
            for (int k = 0; k < run; k++) begin
                queue_req(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_EXTRACT,
                          JOB_W'($urandom_range(255)), pick_burst());
            end
            n_random += run;
        end

        // Hold reset, then release it and let the driver go
        @(posedge clk);
        @(posedge clk);
        rst_n <= 1'b1;

        while (job_reqs.size() != 0 || req_ch.valid || due_replies.size() != 0) begin
            @(posedge clk);
        end
        // Catch any stray response after the last one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d inserted, %0d extracted, %0d refused full, %0d empty",
                 n_accepted, n_inserts, n_extracts, n_full, n_empty);
        $display("Peak occupancy %0d of %0d, %0d mismatches", peak_occ, DEPTH, n_errors);
        if (n_errors == 0 && due_replies.size() == 0) begin
            $display("shortest_job_ready_queue_top test passed");
        end else begin
            $display("shortest_job_ready_queue_top test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sjrq_pkg.sv
hw/rtl/sjrq_if.sv
hw/rtl/shortest_job_ready_queue_top.sv
sim/tb_shortest_job_ready_queue_top.sv
